// File: rtl/running_mean_std_deviation_defines.svh
// assertion macros shared by the running statistics rtl
`ifndef RUNNING_MEAN_STD_DEVIATION_DEFINES_SVH
`define RUNNING_MEAN_STD_DEVIATION_DEFINES_SVH

// condition must never be seen at a clock edge out of reset
`define RMSD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// antecedent in a cycle requires the consequent in the same cycle
`define RMSD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/rmsd_pkg.sv
// types, constants and widths for the running mean and deviation block
package rmsd_pkg;

    // sample fraction bits only fix how values are read; the integer
    // datapath is the same for any fraction width
    localparam int COUNT_BITS  = 16;
    localparam int SAMPLE_BITS = 24;

    // port field widths
    localparam int IN_SAMPLE_W = 24;
    localparam int OUT_COUNT_W = 16;
    localparam int OUT_VAL_W   = 24;

    // accumulator and intermediate widths
    localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int SQR_BITS  = 2 * SAMPLE_BITS;
    localparam int SQ_BITS   = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int RAD_BITS  = 2 * SAMPLE_BITS;
    localparam int ROOT_BITS = SAMPLE_BITS;

    // shared divider: quotient bits per cycle
    localparam int DIV_STEPS  = 4;
    localparam int DIV_CYCLES = (SQ_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIVD_BITS  = DIV_CYCLES * DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    // square root unit: root bits per cycle
    localparam int SQRT_STEPS  = 2;
    localparam int SQRT_CYCLES = (ROOT_BITS + SQRT_STEPS - 1) / SQRT_STEPS;
    localparam int ROOT_PAD    = SQRT_CYCLES * SQRT_STEPS;
    localparam int RAD_PAD     = 2 * ROOT_PAD;
    localparam int SQRT_CNT_W  = $clog2(SQRT_CYCLES + 1);

    // request queue between front and back, depth a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // action codes
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_CLEAR,
        KIND_DROP
    } kind_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_UPDATE
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MEAN_DIV,
        B_MEAN_SQ,
        B_AVG_DIV,
        B_VAR,
        B_POP_SQRT,
        B_VARN,
        B_SMP_DIV,
        B_SMP_SQRT,
        B_OUT
    } back_state_t;

    // accumulator snapshot handed from front to back
    typedef struct packed {
        logic [COUNT_BITS-1:0]      count;
        logic signed [SUM_BITS-1:0] sum;
        logic [SQ_BITS-1:0]         sumsq;
        logic                       dropped;
    } snap_t;

    typedef struct packed {
        logic                  start;
        logic [DIVD_BITS-1:0]  dividend;
        logic [COUNT_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIVD_BITS-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic               start;
        logic [RAD_PAD-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [ROOT_PAD-1:0] root;
    } sqrt_rsp_t;

endpackage

// File: rtl/rmsd_if.sv
// request and result channel interfaces
interface rmsd_item_if
    import rmsd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   action;
    logic [IN_SAMPLE_W-1:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink   (input valid, input action, input sample, output ready);
endinterface

interface rmsd_result_if
    import rmsd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OUT_COUNT_W-1:0] sample_count;
    logic [OUT_VAL_W-1:0]   mean_value;
    logic [OUT_VAL_W-1:0]   std_population;
    logic [OUT_VAL_W-1:0]   std_sample;
    logic                   population_valid;
    logic                   sample_valid;
    logic                   sample_dropped;

    modport source (
        output valid, output sample_count, output mean_value, output std_population,
        output std_sample, output population_valid, output sample_valid,
        output sample_dropped, input ready
    );
    modport sink (
        input valid, input sample_count, input mean_value, input std_population,
        input std_sample, input population_valid, input sample_valid,
        input sample_dropped, output ready
    );
endinterface

// File: rtl/rmsd_front.sv
// front end: accepts requests, classifies them and updates the accumulators
module rmsd_front
    import rmsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    rmsd_item_if.sink        item,
    output logic             push,
    output snap_t            push_data,
    input  logic             full
);

    front_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SQ_BITS-1:0]            sumsq_reg, sumsq_next;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [SQR_BITS-1:0]           sq_reg;
    kind_t                         kind_reg, kind_in;
    logic signed [SQR_BITS-1:0]    prod;
    logic                          accept;

    assign accept = item.valid && item.ready;

    // classify the incoming request against the current count
    always_comb
    begin
        if (item.action == ACT_CLEAR)
            kind_in = KIND_CLEAR;
        else if (count_reg == COUNT_MAX)
            kind_in = KIND_DROP;
        else
            kind_in = KIND_ADD;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_SQUARE;
            end
            F_SQUARE:
                state_next = F_UPDATE;
            F_UPDATE:
            begin
                if (!full)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        item.ready = 1'b0;
        push       = 1'b0;
        unique case (state_reg)
            F_IDLE:   item.ready = 1'b1;
            F_SQUARE: item.ready = 1'b0;
            F_UPDATE: push       = !full;
            default:  item.ready = 1'b0;
        endcase
    end

    // accumulator update for the classified request
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        case (kind_reg)
            KIND_CLEAR:
            begin
                count_next = '0;
                sum_next   = '0;
                sumsq_next = '0;
            end
            KIND_ADD:
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_BITS'(x_reg);
                sumsq_next = sumsq_reg + SQ_BITS'(sq_reg);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign prod = x_reg * x_reg;

    assign push_data.count   = count_next;
    assign push_data.sum     = sum_next;
    assign push_data.sumsq   = sumsq_next;
    assign push_data.dropped = (kind_reg == KIND_DROP);

    // control state and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                count_reg <= count_next;
                sum_reg   <= sum_next;
                sumsq_reg <= sumsq_next;
            end
        end
    end

    // request payload and square
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= $signed(item.sample[SAMPLE_BITS-1:0]);
            kind_reg <= kind_in;
        end
        if (state_reg == F_SQUARE)
            sq_reg <= $unsigned(prod);
    end

endmodule

// File: rtl/rmsd_queue.sv
// short queue of accumulator snapshots between front and back
module rmsd_queue
    import rmsd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  snap_t push_data,
    output logic  full,
    input  logic  pop,
    output snap_t pop_data,
    output logic  empty
);

`include "running_mean_std_deviation_defines.svh"

    snap_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;

    assign full     = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `RMSD_ASSERT_NEVER(a_queue_no_overflow, push && full, "push into full queue")
    `RMSD_ASSERT_NEVER(a_queue_no_underflow, pop && empty, "pop from empty queue")

endmodule

// File: rtl/rmsd_div.sv
// shared restoring divider, several quotient bits per cycle
module rmsd_div
    import rmsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

`include "running_mean_std_deviation_defines.svh"

    logic                  busy_reg, done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVD_BITS-1:0]  work_reg, work_next;
    logic [COUNT_BITS:0]   rem_reg, rem_next;
    logic [COUNT_BITS-1:0] divisor_reg;

    // a few restoring steps per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            rem_next  = {rem_next[COUNT_BITS-1:0], work_next[DIVD_BITS-1]};
            work_next = {work_next[DIVD_BITS-2:0], 1'b0};
            if (rem_next >= {1'b0, divisor_reg})
            begin
                rem_next     = rem_next - {1'b0, divisor_reg};
                work_next[0] = 1'b1;
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_CYCLES);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg    <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    `RMSD_ASSERT_NEVER(a_div_start_when_busy, req.start && busy_reg, "divider restarted")

endmodule

// File: rtl/rmsd_sqrt.sv
// integer square root, digit by digit, a few root bits per cycle
module rmsd_sqrt
    import rmsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic                  busy_reg, done_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [RAD_PAD-1:0]    rad_reg, rad_next;
    logic [ROOT_PAD+1:0]   rem_reg, rem_next;
    logic [ROOT_PAD-1:0]   root_reg, root_next;
    logic [ROOT_PAD+1:0]   trial;

    // bring down two radicand bits per root bit
    always_comb
    begin
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        trial     = '0;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            rem_next = {rem_next[ROOT_PAD-1:0], rad_next[RAD_PAD-1 -: 2]};
            rad_next = {rad_next[RAD_PAD-3:0], 2'b00};
            trial    = {root_next, 2'b01};
            if (rem_next >= trial)
            begin
                rem_next  = rem_next - trial;
                root_next = {root_next[ROOT_PAD-2:0], 1'b1};
            end
            else
            begin
                root_next = {root_next[ROOT_PAD-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQRT_CNT_W'(SQRT_CYCLES);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQRT_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

// File: rtl/rmsd_back.sv
// back end: sequences the divisions and roots and holds the result register
module rmsd_back
    import rmsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  snap_t         pop_data,
    output logic          pop,
    rmsd_result_if.source result
);

`include "running_mean_std_deviation_defines.svh"

    back_state_t state_reg, state_next;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    logic                          launched_reg, launched_next;
    logic [COUNT_BITS-1:0]         cnt_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic [SQ_BITS-1:0]            sumsq_reg;
    logic                          drop_reg;
    logic [SAMPLE_BITS-1:0]        mag_reg;
    logic [SQR_BITS-1:0]           msq_reg;
    logic [SQ_BITS-1:0]            avg_reg;
    logic [RAD_BITS-1:0]           var_reg;
    logic [SQ_BITS-1:0]            varn_reg;
    logic [RAD_BITS-1:0]           sv_reg;
    logic signed [SAMPLE_BITS-1:0] mean_reg;
    logic [ROOT_BITS-1:0]          pop_reg, smp_reg;
    logic                          pop_ok_reg, smp_ok_reg;
    logic                          out_valid_reg, out_load;
    logic [SUM_BITS-1:0]           sum_abs;
    logic signed [SAMPLE_BITS:0]   mean_full;
    logic [SQ_BITS-1:0]            msq_ext;
    logic                          var_ok;
    logic                          in_div, in_sqrt;

    rmsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rmsd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    assign sum_abs   = sum_reg[SUM_BITS-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
    assign mean_full = sum_reg[SUM_BITS-1] ? -$signed({1'b0, mag_reg})
                                           : $signed({1'b0, mag_reg});
    assign msq_ext   = SQ_BITS'(msq_reg);
    assign var_ok    = (avg_reg >= msq_ext);
    assign out_load  = (state_reg == B_OUT) && (!out_valid_reg || result.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                    state_next = B_MEAN_DIV;
            end
            B_MEAN_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = B_OUT;
                else if (div_rsp.done)
                    state_next = B_MEAN_SQ;
            end
            B_MEAN_SQ:
                state_next = B_AVG_DIV;
            B_AVG_DIV:
            begin
                if (div_rsp.done)
                    state_next = B_VAR;
            end
            B_VAR:
                state_next = var_ok ? B_POP_SQRT : B_OUT;
            B_POP_SQRT:
            begin
                if (sqrt_rsp.done)
                    state_next = (cnt_reg > COUNT_BITS'(1)) ? B_VARN : B_OUT;
            end
            B_VARN:
                state_next = B_SMP_DIV;
            B_SMP_DIV:
            begin
                if (div_rsp.done)
                    state_next = B_SMP_SQRT;
            end
            B_SMP_SQRT:
            begin
                if (sqrt_rsp.done)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_load)
                    state_next = B_IDLE;
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    // outputs: queue pop and unit requests
    always_comb
    begin
        pop     = 1'b0;
        in_div  = 1'b0;
        in_sqrt = 1'b0;
        div_req.dividend  = DIVD_BITS'(varn_reg);
        div_req.divisor   = cnt_reg;
        sqrt_req.radicand = RAD_PAD'(sv_reg);
        unique case (state_reg) inside
            B_IDLE:
                pop = !empty;
            B_MEAN_DIV:
            begin
                in_div           = (cnt_reg != '0);
                div_req.dividend = DIVD_BITS'(sum_abs);
            end
            B_AVG_DIV:
            begin
                in_div           = 1'b1;
                div_req.dividend = DIVD_BITS'(sumsq_reg);
            end
            B_SMP_DIV:
            begin
                in_div          = 1'b1;
                div_req.divisor = cnt_reg - 1'b1;
            end
            B_POP_SQRT:
            begin
                in_sqrt           = 1'b1;
                sqrt_req.radicand = RAD_PAD'(var_reg);
            end
            B_SMP_SQRT:
                in_sqrt = 1'b1;
            B_MEAN_SQ, B_VAR, B_VARN, B_OUT:
                pop = 1'b0;
            default:
                pop = 1'b0;
        endcase
        div_req.start  = in_div && !launched_reg;
        sqrt_req.start = in_sqrt && !launched_reg;
    end

    // one launch per unit state, cleared when the unit answers
    always_comb
    begin
        launched_next = launched_reg;
        if (div_req.start || sqrt_req.start)
            launched_next = 1'b1;
        else if (div_rsp.done || sqrt_rsp.done)
            launched_next = 1'b0;
    end

    // control state, flags and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            launched_reg  <= 1'b0;
            pop_ok_reg    <= 1'b0;
            smp_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            if (pop)
            begin
                pop_ok_reg <= 1'b0;
                smp_ok_reg <= 1'b0;
            end
            else if (state_reg == B_VAR && var_ok)
                pop_ok_reg <= 1'b1;
            else if (state_reg == B_SMP_SQRT && sqrt_rsp.done)
                smp_ok_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cnt_reg   <= pop_data.count;
            sum_reg   <= pop_data.sum;
            sumsq_reg <= pop_data.sumsq;
            drop_reg  <= pop_data.dropped;
            mean_reg  <= '0;
            pop_reg   <= '0;
            smp_reg   <= '0;
        end
        if (state_reg == B_MEAN_DIV && div_rsp.done)
            mag_reg <= div_rsp.quotient[SAMPLE_BITS-1:0];
        if (state_reg == B_MEAN_SQ)
        begin
            msq_reg  <= mag_reg * mag_reg;
            mean_reg <= mean_full[SAMPLE_BITS-1:0];
        end
        if (state_reg == B_AVG_DIV && div_rsp.done)
            avg_reg <= div_rsp.quotient[SQ_BITS-1:0];
        if (state_reg == B_VAR)
            var_reg <= RAD_BITS'(avg_reg - msq_ext);
        if (state_reg == B_POP_SQRT && sqrt_rsp.done)
            pop_reg <= sqrt_rsp.root[ROOT_BITS-1:0];
        if (state_reg == B_VARN)
            varn_reg <= var_reg * cnt_reg;
        if (state_reg == B_SMP_DIV && div_rsp.done)
            sv_reg <= div_rsp.quotient[RAD_BITS-1:0];
        if (state_reg == B_SMP_SQRT && sqrt_rsp.done)
            smp_reg <= sqrt_rsp.root[ROOT_BITS-1:0];
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result.sample_count     <= OUT_COUNT_W'(cnt_reg);
            result.mean_value       <= OUT_VAL_W'(mean_reg);
            result.std_population   <= OUT_VAL_W'(pop_reg);
            result.std_sample       <= OUT_VAL_W'(smp_reg);
            result.population_valid <= pop_ok_reg;
            result.sample_valid     <= smp_ok_reg;
            result.sample_dropped   <= drop_reg;
        end
    end

    assign result.valid = out_valid_reg;

    `RMSD_ASSERT_NEVER(a_back_smp_without_pop, smp_ok_reg && !pop_ok_reg, "sample valid alone")
    `RMSD_ASSERT_IMPLIES(a_back_div_done_state, div_rsp.done,
        state_reg == B_MEAN_DIV || state_reg == B_AVG_DIV || state_reg == B_SMP_DIV,
        "divider answer outside a divide state")
    `RMSD_ASSERT_NEVER(a_back_units_overlap, div_rsp.busy && sqrt_rsp.busy, "units overlap")

endmodule

// File: rtl/running_mean_std_deviation.sv
// top level of the running mean and standard deviation block
//
//   channel   dir   payload
//   item      in    action, sample (signed Q15.8)
//   result    out   sample_count, mean_value, std_population, std_sample,
//                   population_valid, sample_valid, sample_dropped
//
// the front takes a new request only after queueing the last one's accumulator snapshot
// the back divides for the mean and mean square, roots the population variance and, for
// two or more samples, divides again by count-1 and takes a second root; with no samples it skips to the result
// reset clears the accumulators, the queue and both sequencers at once
// a stalled result waits in the output register while the front keeps taking
// requests until the snapshot queue fills
module running_mean_std_deviation
    import rmsd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rmsd_item_if.sink     item,
    rmsd_result_if.source result
);

    logic  push, full, pop, empty;
    snap_t push_data, pop_data;

    rmsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    rmsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    rmsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .result   (result)
    );

endmodule
